// ===== sv/svdp_pkg.sv =====
// Shared constants and types for the sparse vector dot product block.
// Used by svdp_mac, sparse_vector_dot_product and the testbench; depends on nothing.
package svdp_pkg;

  localparam int MAX_NONZERO = 256;
  localparam int ADDR_W      = $clog2(MAX_NONZERO);
  localparam int CNT_W       = $clog2(MAX_NONZERO + 1);

  localparam int ID_W   = 16;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 48;

  // One store entry holds the feature id above the feature value.
  localparam int ENTRY_W = ID_W + VAL_W;

  typedef struct packed {
    logic clear;   // start of a new dot product
    logic mul_en;  // register the term of a matched pair
    logic add_en;  // add the registered term into the accumulator
    logic binary;  // term is one instead of the product
  } mac_ctrl_t;

endpackage

// ===== sv/sparse_vector_dot_product.sv =====
// Top level of the sparse vector dot product: merge controller and store.
// Depends on svdp_pkg, svdp_ram and svdp_mac.
//
// This block computes the dot product of two sparse vectors given as
// (feature id, value) pairs in ascending id order. Requests with
// vector_select = 0 load the first vector into a 256-entry store, one element
// per request, and can follow each other back to back; elements beyond 256 are
// dropped. Requests with vector_select = 1 stream the second vector: for each
// one, a merge pointer walks the store past every smaller stored id, and an
// equal id adds the product of the two Q8.8 values (or one, when
// binary_features is set) into a 48-bit saturating accumulator. The request
// with last = 1 that ends the second vector produces one result carrying the
// Q32.16 dot product and a flag that tells whether any addition saturated.
// A streamed request holds the input while it is compared against the
// stored elements and, when it matches, while the term is accumulated;
// the compare loop is set by the single read port of the store and its
// registered read. A finished result sits in an output register, so the
// block keeps taking requests while the result waits; it only holds the
// end of the next vector until that register is free. The store needs no
// clearing after reset, since only entries written by the current load
// are ever read. The configuration register is written through cfg_data
// whenever cfg_valid is high, and must only be changed while no vector is
// being processed.
module sparse_vector_dot_product (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data,
  // Request channel.
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              vector_select,
  input  logic                              has_element,
  input  logic [svdp_pkg::ID_W-1:0]         feature_id,
  input  logic signed [svdp_pkg::VAL_W-1:0] feature_value,
  input  logic                              last,
  // Result channel.
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic signed [svdp_pkg::ACC_W-1:0] dot_product,
  output logic                              overflow
);
  import svdp_pkg::*;

  // S_IDLE takes requests, S_CMP compares one stored element per cycle,
  // S_ADD accumulates a match, S_FIN hands off the result when there is one.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_ADD  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic binary_features;

  // Load side.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_base;
  logic             load_closed;

  // Stream side.
  logic             stream_open;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] ptr_start;
  logic [CNT_W-1:0] ptr_inc;

  logic [ID_W-1:0]         item_id;
  logic signed [VAL_W-1:0] item_val;
  logic                    item_last;

  logic accept;
  logic load_acc;
  logic stream_acc;
  logic res_free;

  // Store ports.
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [ID_W-1:0]    rd_id;
  logic signed [VAL_W-1:0] rd_val;

  mac_ctrl_t               mac_ctrl;
  logic signed [ACC_W-1:0] acc;
  logic                    sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      binary_features <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      binary_features <= cfg_data;
    end
  end

  assign req_stall  = state != S_IDLE;
  assign accept     = req_valid && !req_stall;
  assign load_acc   = accept && !vector_select;
  assign stream_acc = accept && vector_select;
  assign res_free   = !res_valid || !res_stall;

  // A load request after the end of a vector starts the store over.
  assign count_base = load_closed ? '0 : count;
  // A stream request after the end of a vector starts the merge over.
  assign ptr_start  = stream_open ? ptr : '0;
  assign ptr_inc    = ptr + CNT_W'(1);

  assign wr_en   = load_acc && has_element && (count_base != CNT_W'(MAX_NONZERO));
  assign wr_addr = count_base[ADDR_W-1:0];
  assign wr_data = {feature_id, feature_value};

  assign rd_id  = rd_data[ENTRY_W-1:VAL_W];
  assign rd_val = $signed(rd_data[VAL_W-1:0]);

  svdp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NONZERO)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  svdp_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (mac_ctrl),
    .stored_value (rd_val),
    .item_value   (item_val),
    .acc          (acc),
    .sat          (sat)
  );

  // Next state, store reads and accumulator control. The read for the next
  // stored element is issued in the same cycle as the compare of the current
  // one, so the walk advances one element per cycle.
  always_comb begin
    state_next      = state;
    rd_en           = 1'b0;
    rd_addr         = ptr_start[ADDR_W-1:0];
    mac_ctrl.clear  = 1'b0;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.add_en = 1'b0;
    mac_ctrl.binary = binary_features;
    case (state)
      S_IDLE: begin
        if (stream_acc) begin
          mac_ctrl.clear = !stream_open;
          if (has_element && (ptr_start < count)) begin
            rd_en      = 1'b1;
            state_next = S_CMP;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_CMP: begin
        rd_addr = ptr_inc[ADDR_W-1:0];
        if (rd_id < item_id) begin
          if (ptr_inc < count) begin
            rd_en = 1'b1;
          end else begin
            state_next = S_FIN;
          end
        end else if (rd_id == item_id) begin
          mac_ctrl.mul_en = 1'b1;
          state_next      = S_ADD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_ADD: begin
        mac_ctrl.add_en = 1'b1;
        state_next      = S_FIN;
      end
      S_FIN: begin
        if (!item_last || res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      load_closed <= 1'b1;
      stream_open <= 1'b0;
      ptr         <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (load_acc) begin
        count       <= wr_en ? count_base + CNT_W'(1) : count_base;
        load_closed <= last;
      end
      if (stream_acc) begin
        stream_open <= !last;
        ptr         <= ptr_start;
      end
      if ((state == S_CMP) && (rd_id <= item_id)) begin
        ptr <= ptr_inc;
      end
      // A new result may replace one that leaves in the same cycle.
      if ((state == S_FIN) && item_last && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (stream_acc) begin
      item_id   <= feature_id;
      item_val  <= feature_value;
      item_last <= last;
    end
    if ((state == S_FIN) && item_last && res_free) begin
      dot_product <= acc;
      overflow    <= sat;
    end
  end

`ifndef SYNTHESIS
  // The store never holds more elements than it has entries.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_NONZERO))
    else $error("store count beyond capacity");

  // Reads issued in S_CMP only reach elements written by the current load.
  assert property (@(posedge clk) disable iff (rst)
    (rd_en && (state == S_CMP)) |-> (ptr_inc < count))
    else $error("store read beyond the loaded elements");

  // An accumulation always follows a compare that found a match.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |-> ($past(state == S_CMP) && $past(rd_id == item_id)))
    else $error("accumulation without a matching id");

  // A new result only appears after the end of the streamed vector.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state == S_FIN) && $past(item_last)))
    else $error("result without the end of a vector");
`endif

endmodule

// ===== sv/svdp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module svdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/svdp_mac.sv =====
// Multiply and saturating accumulate unit of the sparse dot product.
// Depends on svdp_pkg for widths and the control struct.
module svdp_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  svdp_pkg::mac_ctrl_t               ctrl,
  input  logic signed [svdp_pkg::VAL_W-1:0] stored_value,
  input  logic signed [svdp_pkg::VAL_W-1:0] item_value,
  output logic signed [svdp_pkg::ACC_W-1:0] acc,
  output logic                              sat
);
  import svdp_pkg::*;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [PROD_W-1:0] mult;
  logic signed [PROD_W-1:0] term;
  logic        [ACC_W:0]    sum;
  logic                     clamp;

  assign mult = $signed({{(PROD_W-VAL_W){stored_value[VAL_W-1]}}, stored_value}) *
                $signed({{(PROD_W-VAL_W){item_value[VAL_W-1]}}, item_value});

  // The sum carries one guard bit; a guard bit that differs from the sign
  // bit means the 48-bit range was left.
  assign sum   = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){term[PROD_W-1]}}, term};
  assign clamp = sum[ACC_W] != sum[ACC_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      term <= ctrl.binary ? PROD_W'(1) : mult;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      sat <= 1'b0;
    end else if (ctrl.clear) begin
      acc <= '0;
      sat <= 1'b0;
    end else if (ctrl.add_en) begin
      if (clamp) begin
        acc <= sum[ACC_W] ? ACC_MIN : ACC_MAX;
        sat <= 1'b1;
      end else begin
        acc <= sum[ACC_W-1:0];
      end
    end
  end

endmodule

// ===== sim/sparse_vector_dot_product_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sparse_vector_dot_product: directed and random
// vector pairs, checked against a merge predictor kept inside the bench.
// Depends on svdp_pkg and the sparse_vector_dot_product RTL.
module sparse_vector_dot_product_tb;
  import svdp_pkg::*;

  localparam bit FIRST_VEC    = 1'b0;
  localparam bit SECOND_VEC   = 1'b1;
  localparam bit MODE_PRODUCT = 1'b0;
  localparam bit MODE_COUNT   = 1'b1;

  localparam int MAX_WAIT        = 6;
  localparam int RANDOM_REQUESTS = 300;
  localparam int LONG_HOLD       = 400;
  // One streamed request may walk the whole store.
  localparam int SETTLE_CYCLES   = 300;
  localparam longint CYCLE_LIMIT = 1000000;

  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic                    clamped;
  } dot_result_t;

  logic                    clk;
  logic                    rst           = 1'b1;
  logic                    cfg_valid     = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_data      = 1'b0;
  logic                    req_valid     = 1'b0;
  logic                    req_stall;
  logic                    vector_select = 1'b0;
  logic                    has_element   = 1'b0;
  logic [ID_W-1:0]         feature_id    = '0;
  logic signed [VAL_W-1:0] feature_value = '0;
  logic                    last          = 1'b0;
  logic                    res_valid;
  logic                    res_stall     = 1'b0;
  logic signed [ACC_W-1:0] dot_product;
  logic                    overflow;

  sparse_vector_dot_product DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .vector_select (vector_select),
    .has_element   (has_element),
    .feature_id    (feature_id),
    .feature_value (feature_value),
    .last          (last),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .dot_product   (dot_product),
    .overflow      (overflow)
  );

  // Predictor state: the stored vector, the merge walk and the running sum.
  logic [ID_W-1:0]         kept_ids  [MAX_NONZERO];
  logic signed [VAL_W-1:0] kept_vals [MAX_NONZERO];
  int     kept_count    = 0;
  int     walk_ptr      = 0;
  longint running_sum   = 0;
  bit     sum_clamped   = 1'b0;
  bit     load_done     = 1'b1;
  bit     stream_active = 1'b0;
  bit     count_mode    = MODE_PRODUCT;

  dot_result_t expected_dots [$];

  // Stimulus scratch: the vector about to be sent and the last one loaded.
  logic [ID_W-1:0]         vec_ids    [$];
  logic signed [VAL_W-1:0] vec_vals   [$];
  logic [ID_W-1:0]         loaded_ids [$];

  bit     idling            = 1'b1;
  int     stall_left        = 0;
  int     hold_left         = 0;
  int     errors            = 0;
  int     requests_sent     = 0;
  int     counted_requests  = 0;
  int     results_seen      = 0;
  longint cycle_count       = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sparse_vector_dot_product_tb: done, errors");
      $finish;
    end
  end

  function automatic void add_term(longint term);
    longint s;
    s = running_sum + term;
    if (s > SUM_MAX) begin
      s = SUM_MAX;
      sum_clamped = 1'b1;
    end else if (s < SUM_MIN) begin
      s = SUM_MIN;
      sum_clamped = 1'b1;
    end
    running_sum = s;
  endfunction

  // Applies one accepted request to the predictor; the request that closes
  // the second vector queues the expected dot product.
  function automatic void merge_request(bit sel, bit has, logic [ID_W-1:0] id,
                                        logic signed [VAL_W-1:0] val, bit is_last);
    dot_result_t r;
    if (sel == FIRST_VEC) begin
      if (load_done) begin
        kept_count = 0;
        load_done  = 1'b0;
      end
      if (has && kept_count < MAX_NONZERO) begin
        kept_ids[kept_count]  = id;
        kept_vals[kept_count] = val;
        kept_count++;
      end
      if (is_last) load_done = 1'b1;
    end else begin
      if (!stream_active) begin
        walk_ptr      = 0;
        running_sum   = 0;
        sum_clamped   = 1'b0;
        stream_active = 1'b1;
      end
      if (has) begin
        while (walk_ptr < kept_count && kept_ids[walk_ptr] < id) walk_ptr++;
        if (walk_ptr < kept_count && kept_ids[walk_ptr] == id) begin
          if (count_mode == MODE_COUNT) add_term(1);
          else add_term(longint'(kept_vals[walk_ptr]) * longint'(val));
          walk_ptr++;
        end
      end
      if (is_last) begin
        stream_active = 1'b0;
        r.sum     = running_sum[ACC_W-1:0];
        r.clamped = sum_clamped;
        expected_dots.push_back(r);
      end
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
             $time, what, results_seen, got, want);
  endtask

  // Result checker: every accepted result is compared with the oldest
  // expectation, and the wait before the next result is drawn here.
  always @(posedge clk) begin : check_results
    dot_result_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (expected_dots.size() == 0) begin
        report_mismatch("unexpected result", longint'(dot_product), 0);
      end else begin
        want = expected_dots.pop_front();
        if (dot_product !== want.sum)
          report_mismatch("dot_product", longint'(dot_product), longint'($signed(want.sum)));
        if (overflow !== want.clamped)
          report_mismatch("overflow", longint'(overflow), longint'(want.clamped));
      end
      stall_left = idling ? $urandom_range(0, MAX_WAIT) : 0;
    end
  end

  // Receiver stall: a long hold set by a test, else the per-result wait.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Offers one request, after a random gap when idling, and returns at the accepting edge.
  // Valid stays high afterwards so that back-to-back requests need no bubble.
  task automatic send_request(bit sel, bit has, logic [ID_W-1:0] id,
                              logic signed [VAL_W-1:0] val, bit is_last);
    int gap;
    gap = idling ? $urandom_range(0, MAX_WAIT) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid     <= 1'b1;
    vector_select <= sel;
    has_element   <= has;
    feature_id    <= id;
    feature_value <= val;
    last          <= is_last;
    forever begin
      @(posedge clk);
      if (req_valid && !req_stall) break;
    end
    merge_request(sel, has, id, val, is_last);
    requests_sent++;
    if (has || is_last) counted_requests++;
  endtask

  // Lowers valid and waits until every expected result has arrived, then
  // long enough for any request that gives no result to finish.
  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_dots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(bit mode);
    wait_for_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    count_mode = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_element(logic [ID_W-1:0] id, logic signed [VAL_W-1:0] val);
    vec_ids.push_back(id);
    vec_vals.push_back(val);
  endtask

  // Sends the scratch vector; an empty one becomes a single closing request.
  // With close low the vector is sent without its closing flag.
  task automatic send_vector(bit sel, bit close);
    if (vec_ids.size() == 0) begin
      if (close) send_request(sel, 1'b0, ID_W'($urandom), VAL_W'($urandom), 1'b1);
    end else begin
      for (int i = 0; i < vec_ids.size(); i++)
        send_request(sel, 1'b1, vec_ids[i], vec_vals[i], close && i == vec_ids.size() - 1);
    end
  endtask

  task automatic fill_ascending(int count, int stride);
    int next_id;
    vec_ids.delete();
    vec_vals.delete();
    next_id = $urandom_range(0, 65535) >> $urandom_range(0, 16);
    for (int i = 0; i < count && next_id <= 65535; i++) begin
      push_element(ID_W'(next_id), VAL_W'($urandom));
      next_id += $urandom_range(0, stride);
    end
  endtask

  // Builds a second vector that hits some loaded ids, misses just below
  // others, and sometimes runs past the end of the load.
  task automatic fill_stream_against_load();
    int prev;
    vec_ids.delete();
    vec_vals.delete();
    prev = 0;
    foreach (loaded_ids[k]) begin
      if ($urandom_range(0, 3) == 0 && loaded_ids[k] > prev) begin
        prev = loaded_ids[k] - 1;
        push_element(ID_W'(prev), VAL_W'($urandom));
      end
      if ($urandom_range(0, 2) != 0) begin
        prev = loaded_ids[k];
        push_element(ID_W'(prev), VAL_W'($urandom));
      end
    end
    if ($urandom_range(0, 2) == 0)
      push_element(ID_W'($urandom_range(prev, 65535)), VAL_W'($urandom));
  endtask

  task automatic load_random_vector();
    int size;
    int stride;
    size = ($urandom_range(0, 29) == 0) ? $urandom_range(240, 270) : $urandom_range(0, 12);
    case ($urandom_range(0, 3))
      0: stride = 1;
      1: stride = 3;
      2: stride = 50;
      default: stride = 3000;
    endcase
    fill_ascending(size, stride);
    send_vector(FIRST_VEC, 1'b1);
    loaded_ids = vec_ids;
  endtask

  task automatic test_directed_cases();
    // Nothing loaded since reset: the stream merges against an empty store.
    send_request(SECOND_VEC, 1'b1, 16'h1234, 16'sh0100, 1'b1);
    // Empty first vector.
    send_request(FIRST_VEC, 1'b0, 16'h0000, 16'sh0000, 1'b1);
    send_request(SECOND_VEC, 1'b1, 16'h0005, 16'sh7FFF, 1'b1);
    // Extreme ids and values; each vector opens with an element-free request.
    send_request(FIRST_VEC, 1'b0, 16'hFFFF, 16'sh7FFF, 1'b0);
    send_request(FIRST_VEC, 1'b1, 16'h0000, 16'sh8000, 1'b0);
    send_request(FIRST_VEC, 1'b1, 16'h0001, 16'sh7FFF, 1'b0);
    send_request(FIRST_VEC, 1'b1, 16'hFFFF, 16'sh8000, 1'b1);
    send_request(SECOND_VEC, 1'b0, 16'hFFFF, 16'sh8000, 1'b0);
    send_request(SECOND_VEC, 1'b1, 16'h0000, 16'sh8000, 1'b0);
    send_request(SECOND_VEC, 1'b1, 16'h0001, 16'sh8000, 1'b0);
    send_request(SECOND_VEC, 1'b1, 16'h0002, 16'sh0001, 1'b0);
    send_request(SECOND_VEC, 1'b1, 16'hFFFF, 16'sh7FFF, 1'b1);
    // Empty second vector.
    send_request(SECOND_VEC, 1'b0, 16'h0000, 16'sh0000, 1'b1);
    // Ids out of order: the second one lies below the pointer and misses.
    send_request(SECOND_VEC, 1'b1, 16'hFFFF, 16'sh0001, 1'b0);
    send_request(SECOND_VEC, 1'b1, 16'h0000, 16'sh0001, 1'b1);
    // Reload in the middle of a stream; the pointer carries over.
    send_request(SECOND_VEC, 1'b1, 16'h0000, 16'sh0100, 1'b0);
    send_request(FIRST_VEC, 1'b1, 16'h0000, 16'sh0002, 1'b0);
    send_request(FIRST_VEC, 1'b1, 16'h0001, 16'shFFFD, 1'b1);
    send_request(SECOND_VEC, 1'b1, 16'h0001, 16'sh0100, 1'b1);
  endtask

  // Loads more elements than the store holds; only the first 256 can match.
  task automatic test_store_overflow();
    for (int i = 0; i < MAX_NONZERO + 4; i++)
      send_request(FIRST_VEC, 1'b1, ID_W'(i), VAL_W'($urandom), i == MAX_NONZERO + 3);
    for (int i = MAX_NONZERO - 6; i < MAX_NONZERO + 4; i++)
      send_request(SECOND_VEC, 1'b1, ID_W'(i), VAL_W'($urandom), i == MAX_NONZERO + 3);
  endtask

  // A full store of equal ids gives 256 matches, the largest sums reachable.
  // The pointer never rewinds inside a dot product, so 256 products of at
  // most 2^30 stay far below the 48-bit clamp.
  task automatic test_largest_sums();
    for (int i = 0; i < MAX_NONZERO; i++)
      send_request(FIRST_VEC, 1'b1, 16'h0007, 16'sh8000, i == MAX_NONZERO - 1);
    for (int i = 0; i < MAX_NONZERO; i++)
      send_request(SECOND_VEC, 1'b1, 16'h0007, 16'sh8000, i == MAX_NONZERO - 1);
    for (int i = 0; i < MAX_NONZERO; i++)
      send_request(SECOND_VEC, 1'b1, 16'h0007, 16'sh7FFF, i == MAX_NONZERO - 1);
  endtask

  task automatic test_count_mode();
    set_mode(MODE_COUNT);
    for (int i = 0; i < MAX_NONZERO; i++)
      send_request(SECOND_VEC, 1'b1, 16'h0007, VAL_W'($urandom), i == MAX_NONZERO - 1);
    // Repeated ids pair up one to one with stored copies; a surplus one misses.
    send_request(FIRST_VEC, 1'b1, 16'h0003, 16'sh0010, 1'b0);
    send_request(FIRST_VEC, 1'b1, 16'h0003, 16'sh0020, 1'b0);
    send_request(FIRST_VEC, 1'b1, 16'h0003, 16'sh0030, 1'b0);
    send_request(FIRST_VEC, 1'b1, 16'h0009, 16'sh0040, 1'b1);
    send_request(SECOND_VEC, 1'b1, 16'h0003, 16'sh0001, 1'b0);
    send_request(SECOND_VEC, 1'b1, 16'h0003, 16'sh0001, 1'b0);
    send_request(SECOND_VEC, 1'b1, 16'h0009, 16'sh0001, 1'b0);
    send_request(SECOND_VEC, 1'b1, 16'h0009, 16'sh0001, 1'b1);
    repeat (8) begin
      load_random_vector();
      fill_stream_against_load();
      send_vector(SECOND_VEC, 1'b1);
    end
    set_mode(MODE_PRODUCT);
  endtask

  // The receiver holds off while small vector pairs keep coming, so the
  // output register fills and the block stalls its input; then the sender
  // pauses until every result is in.
  task automatic test_backpressure();
    idling    = 1'b0;
    hold_left = LONG_HOLD;
    repeat (12) begin
      fill_ascending($urandom_range(1, 4), 3);
      send_vector(FIRST_VEC, 1'b1);
      loaded_ids = vec_ids;
      fill_stream_against_load();
      send_vector(SECOND_VEC, 1'b1);
    end
    wait_for_results();
    idling = 1'b1;
  endtask

  task automatic test_random_pairs();
    int start;
    int kind;
    start = counted_requests;
    while (counted_requests - start < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 39) == 0) set_mode(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 11) == 0) idling = ($urandom_range(0, 2) != 0);
      kind = $urandom_range(0, 19);
      if (kind <= 11) begin
        load_random_vector();
        fill_stream_against_load();
        send_vector(SECOND_VEC, 1'b1);
      end else if (kind <= 13) begin
        // Another second vector against the load already in place.
        fill_stream_against_load();
        send_vector(SECOND_VEC, 1'b1);
      end else if (kind == 14) begin
        repeat ($urandom_range(1, 3))
          send_request(1'($urandom_range(0, 1)), 1'b0, ID_W'($urandom), VAL_W'($urandom),
                       1'b0);
      end else if (kind == 15) begin
        // Second vector with ids in no particular order.
        vec_ids.delete();
        vec_vals.delete();
        repeat ($urandom_range(1, 6)) begin
          if (loaded_ids.size() > 0 && $urandom_range(0, 1) == 1)
            push_element(loaded_ids[$urandom_range(0, loaded_ids.size() - 1)],
                         VAL_W'($urandom));
          else
            push_element(ID_W'($urandom), VAL_W'($urandom));
        end
        send_vector(SECOND_VEC, 1'b1);
      end else if (kind == 16) begin
        // Part of a stream, a new load, then the rest of the stream.
        fill_stream_against_load();
        send_vector(SECOND_VEC, 1'b0);
        load_random_vector();
        fill_stream_against_load();
        send_vector(SECOND_VEC, 1'b1);
      end else if (kind <= 18) begin
        repeat ($urandom_range(1, 8))
          send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ID_W'($urandom),
                       VAL_W'($urandom), $urandom_range(0, 2) == 0);
      end else begin
        // An empty vector on one side or the other.
        if ($urandom_range(0, 1) == 1) begin
          vec_ids.delete();
          vec_vals.delete();
          send_vector(FIRST_VEC, 1'b1);
          loaded_ids = vec_ids;
          fill_ascending($urandom_range(1, 5), 50);
        end else begin
          vec_ids.delete();
          vec_vals.delete();
        end
        send_vector(SECOND_VEC, 1'b1);
      end
    end
    idling = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_mode(MODE_PRODUCT);
    test_directed_cases();
    test_store_overflow();
    test_largest_sums();
    test_count_mode();
    test_backpressure();
    test_random_pairs();
    wait_for_results();

    $display("Sent %0d requests and checked %0d dot products in both accumulate modes,",
             requests_sent, results_seen);
    $display("including a full store, reloads mid-stream and a long result hold-off.");
    if (errors == 0) begin
      $display("sparse_vector_dot_product_tb: done, clean");
    end else begin
      $display("sparse_vector_dot_product_tb: done, errors");
    end
    $finish;
  end

endmodule
